// ----- rtl/tklp_pkg.sv -----
// tklp_pkg: shared types and codes of the top-k local peak tracker.
// No dependencies; used by tklp_cell and top_k_local_peak_tracker.
`timescale 1ns / 1ps

package tklp_pkg;

  // item kind carried on s_tuser
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // per-cell compare result against the candidate peak
  typedef struct packed {
    logic gt;   // held entry is in use and larger than candidate
    logic eq;   // held entry is in use and equals candidate
  } cell_flags_t;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

endpackage

// ----- rtl/tklp_cell.sv -----
// tklp_cell: one slot of the sorted peak chain, with its compare and shift.
// Depends on tklp_pkg.
`timescale 1ns / 1ps

module tklp_cell
  import tklp_pkg::*;
#(
  parameter int SB  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          ins,        // insertion takes place this cycle
  input  logic [SB-1:0] new_val,    // candidate peak
  input  logic [SB-1:0] left_val,   // entry of the cell one rank up
  input  logic          left_gt,    // cell one rank up stays put
  input  logic [CW-1:0] ceff,       // entries in use for this attempt
  output logic [SB-1:0] val,
  output cell_flags_t   flags
);

  logic [SB-1:0] entry;
  logic          in_use;

  assign in_use    = CW'(IDX) < ceff;
  assign flags.gt  = in_use && ($signed(entry) > $signed(new_val));
  assign flags.eq  = in_use && (entry == new_val);
  assign val       = entry;

  // at the insertion point take the candidate, below it take the neighbour
  always_ff @(posedge clk) begin
    if (ins && !flags.gt) begin
      entry <= left_gt ? new_val : left_val;
    end
  end

endmodule

// ----- rtl/top_k_local_peak_tracker.sv -----
// top_k_local_peak_tracker: top level, sample window, insertion chain and dump.
// Depends on tklp_pkg and tklp_cell.
`timescale 1ns / 1ps
//
// Usage:
//   s_* takes one item per handshake; s_tuser is the opcode (push, dump,
//   clear), s_tdata the sample. On a push the two previous samples and the
//   new one are tested for a strict local maximum and the middle sample is
//   inserted into the descending chain of cells in the same cycle unless it
//   is a duplicate or below a full list. A clear resets list and samples.
//   A dump emits one result per cycle on m_* while m_tready is high, largest
//   first, m_tlast on the final one; an empty list gives a single result
//   with entry_valid low. The first result is registered from the ST_DUMP
//   state entered when the dump is accepted; s_tready stays low until the
//   last result has entered the output register, as the single read port
//   walks the chain. Write list_limit on cfg_* only while idle; the block
//   itself does not enforce it, and cfg_ready is high. A stalled m_tready
//   holds the output register and pauses the dump walk. rst (synchronous)
//   empties the list, forgets the samples and sets the limit to 16.
module top_k_local_peak_tracker
  import tklp_pkg::*;
#(
  parameter int MAX_PEAKS   = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [SB-1:0] sample
  input  logic [1:0] s_tuser,                        // [1:0] opcode
  output logic m_tvalid,
  input  logic m_tready,
  // from bit 0: peak_value, rank, peak_count, entry_valid
  output logic [((SAMPLE_BITS + (MAX_PEAKS > 1 ? $clog2(MAX_PEAKS) : 1)
                 + $clog2(MAX_PEAKS+1) + 1 + 7)/8)*8-1:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int RW    = MAX_PEAKS > 1 ? $clog2(MAX_PEAKS) : 1;
  localparam int CW    = $clog2(MAX_PEAKS+1);
  localparam int OUT_W = ((SB + RW + CW + 1 + 7)/8)*8;

  logic [4:0]    list_limit;
  logic [SB-1:0] older_sample;
  logic [SB-1:0] middle_sample;
  logic [1:0]    samples_seen;
  logic [CW-1:0] list_count;
  logic [CW-1:0] list_count_next;

  state_t state;
  state_t state_next;
  logic [RW-1:0] dump_idx;
  logic [CW-1:0] dump_n;

  logic [SB-1:0] o_val;
  logic [RW-1:0] o_rank;
  logic [CW-1:0] o_cnt;
  logic          o_ev;

  logic [SB-1:0] sample;
  opcode_t       opcode;
  logic          in_acc;
  logic          push_acc;
  logic          dump_acc;
  logic          clear_acc;
  logic          out_load;
  logic          dump_last;

  logic [CW-1:0] lim;
  logic [CW-1:0] ceff;
  logic [CW:0]   grown;
  logic          is_peak;
  logic          attempt;
  logic          ins;

  logic [SB-1:0] vals [MAX_PEAKS];
  cell_flags_t   flags [MAX_PEAKS];
  logic [MAX_PEAKS-1:0] eq_vec;
  logic [MAX_PEAKS-1:0] tail_vec;

  assign cfg_ready = 1'b1;
  assign sample    = s_tdata[SB-1:0];
  assign opcode    = opcode_t'(s_tuser);
  assign in_acc    = s_tvalid && s_tready;

  always_comb begin
    push_acc  = 1'b0;
    dump_acc  = 1'b0;
    clear_acc = 1'b0;
    unique case (opcode)
      OP_PUSH:  push_acc  = in_acc;
      OP_DUMP:  dump_acc  = in_acc;
      OP_CLEAR: clear_acc = in_acc;
      default: ;
    endcase
  end

  // effective limit: 0 acts as 1, above capacity acts as capacity
  always_comb begin
    if (list_limit == 5'd0) begin
      lim = CW'(1);
    end else if (32'(list_limit) > MAX_PEAKS) begin
      lim = CW'(MAX_PEAKS);
    end else begin
      lim = CW'(list_limit);
    end
  end

  assign ceff    = (list_count > lim) ? lim : list_count;
  assign grown   = {1'b0, ceff} + (CW+1)'(1);
  assign is_peak = ($signed(older_sample) < $signed(middle_sample)) &&
                   ($signed(sample) < $signed(middle_sample));
  assign attempt = push_acc && (samples_seen == 2'd2) && is_peak;
  // skip duplicates, and a candidate below every entry of a full list
  assign ins     = attempt && !(|eq_vec) && !(|tail_vec);

  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_chain
    logic [SB-1:0] lval;
    logic          lgt;
    if (i == 0) begin : g_head
      assign lval = middle_sample;
      assign lgt  = 1'b1;
    end else begin : g_body
      assign lval = vals[i-1];
      assign lgt  = flags[i-1].gt;
    end

    tklp_cell #(
      .SB  (SB),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ins      (ins),
      .new_val  (middle_sample),
      .left_val (lval),
      .left_gt  (lgt),
      .ceff     (ceff),
      .val      (vals[i]),
      .flags    (flags[i])
    );

    assign eq_vec[i]   = flags[i].eq;
    assign tail_vec[i] = flags[i].gt && (CW'(i+1) == lim);
  end

  always_comb begin
    list_count_next = list_count;
    if (clear_acc) begin
      list_count_next = '0;
    end else if (ins) begin
      list_count_next = (grown > {1'b0, lim}) ? lim : grown[CW-1:0];
    end else if (attempt) begin
      list_count_next = ceff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit    <= LIMIT_RESET;
      older_sample  <= '0;
      middle_sample <= '0;
      samples_seen  <= '0;
      list_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        list_limit <= cfg_data;
      end
      list_count <= list_count_next;
      if (clear_acc) begin
        older_sample  <= '0;
        middle_sample <= '0;
        samples_seen  <= '0;
      end else if (push_acc) begin
        older_sample  <= middle_sample;
        middle_sample <= sample;
        if (samples_seen != 2'd2) begin
          samples_seen <= samples_seen + 2'd1;
        end
      end
    end
  end

  // dump walk
  assign dump_last = (dump_n == '0) ||
                     (({1'b0, CW'(dump_idx)} + (CW+1)'(1)) == {1'b0, dump_n});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (dump_acc) state_next = ST_DUMP;
      ST_DUMP: if (out_load && dump_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DUMP: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      dump_idx <= '0;
      dump_n   <= '0;
    end else begin
      state <= state_next;
      if (dump_acc) begin
        dump_idx <= '0;
        dump_n   <= list_count;
      end else if (out_load) begin
        dump_idx <= dump_idx + RW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_val   <= (dump_n == '0) ? '0 : vals[dump_idx];
      o_rank  <= dump_idx;
      o_cnt   <= dump_n;
      o_ev    <= (dump_n != '0);
      m_tlast <= dump_last;
    end
  end

  assign m_tdata = OUT_W'({o_ev, o_cnt, o_rank, o_val});

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    list_count <= CW'(MAX_PEAKS))
    else $error("list count beyond capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !o_ev) |-> (m_tlast && (o_cnt == '0)))
    else $error("empty-list item must be last with zero count");

  a_dump_holds_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> $stable(list_count))
    else $error("list changed during dump");

  a_grow_by_one: assert property (@(posedge clk) disable iff (rst)
    ins |=> ({1'b0, list_count} <= {1'b0, $past(list_count)} + (CW+1)'(1)))
    else $error("insertion grew list by more than one");
`endif

endmodule
